### rtl/core/cfa_pkg.sv
`default_nettype none

package cfa_pkg;

   localparam int FRAC_BITS = 32;
   localparam int IN_W      = 48;
   localparam int INT_W     = IN_W - FRAC_BITS;
   localparam int P_W       = 32;
   localparam int Q_W       = 31;
   localparam int TOL_W     = 32;
   localparam int STEP_W    = 6;
   localparam int OP_W      = 33;
   localparam int PROD_W    = 2 * OP_W;
   localparam int ACC_W     = 82;
   localparam int LIM_W     = 63;
   localparam int QUO_W     = 2 * FRAC_BITS + 1;
   localparam int DCNT_W    = 7;
   localparam int ADDR_W    = 3;
   localparam int CSR_W     = 32;

   localparam logic REG_TOLERANCE = 1'b0;
   localparam logic REG_MAX_STEPS = 1'b1;

   localparam logic [TOL_W-1:0]  TOL_RESET   = 32'd4295;
   localparam logic [STEP_W-1:0] STEPS_RESET = 6'd30;

   localparam logic [P_W-1:0] P_MAX = 32'h7FFF_FFFF;
   localparam logic [P_W-1:0] P_MIN = 32'h8000_0000;
   localparam logic [Q_W-1:0] Q_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
   } mul_op_type;

endpackage

`default_nettype wire

### rtl/core/cfa_mul.sv
`default_nettype none

module cfa_mul (
   input  logic                                clock,
   input  cfa_pkg::mul_op_type                 op,
   output logic signed [cfa_pkg::PROD_W-1:0]   prod_ff
);
   import cfa_pkg::*;

   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op.a) * PROD_W'(op.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### rtl/core/cfa_div.sv
`default_nettype none

module cfa_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cfa_pkg::FRAC_BITS-1:0] divisor,
   output logic                          done_ff,
   output logic [cfa_pkg::QUO_W-1:0]     quot_ff
);
   import cfa_pkg::*;

   logic [FRAC_BITS-1:0] rem_ff, rem_in;
   logic [FRAC_BITS-1:0] dvs_ff;
   logic [DCNT_W-1:0]    cnt_ff;
   logic                 busy_ff;
   logic                 bit_in;
   logic [FRAC_BITS:0]   shifted;
   logic [FRAC_BITS:0]   diff;
   logic                 ge;

   // dividend is 2^(2*FRAC_BITS): only its top bit is set
   assign bit_in  = (cnt_ff == DCNT_W'(QUO_W));
   assign shifted = {rem_ff, bit_in};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});
   assign rem_in  = ge ? diff[FRAC_BITS-1:0] : shifted[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(QUO_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DCNT_W'(1);
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[QUO_W-2:0], ge};
      end
   end

endmodule

`default_nettype wire

### rtl/core/continued_fraction_approximator.sv
`default_nettype none
// Channel | Dir | Width | Contents
// req     | in  | 48    | tdata: value_in
// rsp     | out | 64    | tdata: numer [31:0], denom [62:32]; tuser: overflow
// csr     | in  | 32    | APB: 0x0 tolerance, 0x4 max_steps
//
// Each refinement step runs one loop state, five tolerance-check states, the bit-serial
// reciprocal divider and three convergent-update states. At the default max_steps, an
// item takes at most 29 refinement steps.
// req_tready is high only while no item is at work; one result register holds the
// finished result, and a done item waits there until rsp_tready frees it.
// Synchronous reset restores tolerance 4295 and max_steps 30 and empties the block.

module continued_fraction_approximator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [47:0]                 req_tdata,   // value_in[47:0]
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,   // numer[31:0], denom[62:32], zero[63]
   output logic                        rsp_tuser,   // overflow
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [cfa_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [cfa_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [cfa_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import cfa_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LOOP = 4'd1;
   localparam logic [3:0] S_CK1  = 4'd2;
   localparam logic [3:0] S_CK2  = 4'd3;
   localparam logic [3:0] S_CK3  = 4'd4;
   localparam logic [3:0] S_CK4  = 4'd5;
   localparam logic [3:0] S_CK5  = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_UP1  = 4'd8;
   localparam logic [3:0] S_UP2  = 4'd9;
   localparam logic [3:0] S_UP3  = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   logic [3:0]              state_ff, state_in;
   logic [TOL_W-1:0]        tol_ff;
   logic [STEP_W-1:0]       max_steps_ff;
   logic [IN_W-1:0]         x_ff, x_in;
   logic signed [P_W-1:0]   p_ff, p_in, pp_ff, pp_in, np_ff, np_in;
   logic [Q_W-1:0]          q_ff, q_in, qp_ff, qp_in;
   logic [FRAC_BITS-1:0]    f_ff, f_in, a_ff, a_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [LIM_W-1:0]        lim_ff, lim_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             rsp_data_ff, rsp_data_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic [STEP_W:0]         step_nx;
   logic signed [PROD_W-1:0] sum_p;
   logic [PROD_W-1:0]       sum_q;
   logic [PROD_W-P_W:0]     p_hi;
   logic                    q_sat;
   logic                    csr_wr;

   mul_op_type               mul_op;
   logic signed [PROD_W-1:0] prod;
   logic                     div_start;
   logic                     div_done;
   logic [QUO_W-1:0]         quot;

   cfa_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (prod)
   );

   cfa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (f_ff),
      .done_ff (div_done),
      .quot_ff (quot)
   );

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_STEPS) ?
                       {{(CSR_W-STEP_W){1'b0}}, max_steps_ff} : tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         max_steps_ff <= STEPS_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_TOLERANCE) tol_ff <= csr_pwdata;
         else max_steps_ff <= csr_pwdata[STEP_W-1:0];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

   assign step_nx = {1'b0, step_ff} + (STEP_W+1)'(1);
   assign sum_p   = prod + PROD_W'(pp_ff);
   assign sum_q   = $unsigned(prod) + PROD_W'(qp_ff);
   assign p_hi    = sum_p[PROD_W-1:P_W-1];
   assign q_sat   = |sum_q[PROD_W-1:Q_W];

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      pp_in        = pp_ff;
      np_in        = np_ff;
      q_in         = q_ff;
      qp_in        = qp_ff;
      f_in         = f_ff;
      a_in         = a_ff;
      acc_in       = acc_ff;
      lim_in       = lim_ff;
      step_in      = step_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mul_op.a     = '0;
      mul_op.b     = '0;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata;
               p_in     = P_W'(signed'(req_tdata[IN_W-1:FRAC_BITS]));
               pp_in    = P_W'(1);
               q_in     = Q_W'(1);
               qp_in    = '0;
               f_in     = req_tdata[FRAC_BITS-1:0];
               step_in  = '0;
               ovf_in   = 1'b0;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (step_nx < {1'b0, max_steps_ff}) begin
               step_in  = step_nx[STEP_W-1:0];
               state_in = S_CK1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_CK1: begin
            mul_op.a = OP_W'(signed'(x_ff[IN_W-1:FRAC_BITS]));
            mul_op.b = {2'b00, q_ff};
            state_in = S_CK2;
         end
         S_CK2: begin
            acc_in   = ACC_W'(prod) - ACC_W'(p_ff);
            mul_op.a = {1'b0, x_ff[FRAC_BITS-1:0]};
            mul_op.b = {2'b00, q_ff};
            state_in = S_CK3;
         end
         S_CK3: begin
            acc_in   = (acc_ff <<< FRAC_BITS) + ACC_W'(prod);
            mul_op.a = {1'b0, tol_ff};
            mul_op.b = {2'b00, q_ff};
            state_in = S_CK4;
         end
         S_CK4: begin
            lim_in   = prod[LIM_W-1:0];
            acc_in   = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
            state_in = S_CK5;
         end
         S_CK5: begin
            if (($unsigned(acc_ff) < ACC_W'(lim_ff)) || (f_ff == '0)) begin
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (quot[QUO_W-1]) begin
                  a_in   = '1;
                  ovf_in = 1'b1;
               end else begin
                  a_in = quot[QUO_W-2:FRAC_BITS];
               end
               f_in     = quot[FRAC_BITS-1:0];
               state_in = S_UP1;
            end
         end
         S_UP1: begin
            mul_op.a = {1'b0, a_ff};
            mul_op.b = OP_W'(p_ff);
            state_in = S_UP2;
         end
         S_UP2: begin
            if (!((&p_hi) || !(|p_hi))) begin
               np_in  = p_hi[PROD_W-P_W] ? P_MIN : P_MAX;
               ovf_in = 1'b1;
            end else begin
               np_in = sum_p[P_W-1:0];
            end
            mul_op.a = {1'b0, a_ff};
            mul_op.b = {2'b00, q_ff};
            state_in = S_UP3;
         end
         S_UP3: begin
            pp_in = p_ff;
            qp_in = q_ff;
            p_in  = np_ff;
            q_in  = q_sat ? Q_MAX : sum_q[Q_W-1:0];
            if (q_sat) ovf_in = 1'b1;
            state_in = (ovf_ff || q_sat) ? S_DONE : S_LOOP;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, q_ff, p_ff};
               rsp_ovf_in   = ovf_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      p_ff        <= p_in;
      pp_ff       <= pp_in;
      np_ff       <= np_in;
      q_ff        <= q_in;
      qp_ff       <= qp_in;
      f_ff        <= f_in;
      a_ff        <= a_in;
      acc_ff      <= acc_in;
      lim_ff      <= lim_in;
      step_ff     <= step_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

`ifndef ASSERT_OFF
   a_denom_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[62:32] != '0))
      else $error("result denominator is zero");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised without a finished item");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CK1) |-> (step_ff < max_steps_ff))
      else $error("refinement step beyond the step bound");
`endif

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cfa_pkg::*;

   localparam int GAP_MAX       = 18;
   localparam int HOLD_AT       = 60;
   localparam int HOLD_CYCLES   = 6000;
   localparam int STALL_LIMIT   = 30000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 50;
   localparam int SETTLE_CYCLES = 100;

   localparam logic [IN_W-1:0] PI_FIX    = 48'h3_243F_6A88;
   localparam logic [IN_W-1:0] SQRT2_FIX = 48'h1_6A09_E667;

   localparam logic signed [127:0] UNIT     = 128'sh1_0000_0000;
   localparam logic signed [127:0] TERM_MAX = 128'shFFFF_FFFF;
   localparam logic signed [127:0] NUM_MAX  = 128'sh7FFF_FFFF;
   localparam logic signed [127:0] NUM_MIN  = -128'sh8000_0000;
   localparam logic signed [127:0] DEN_MAX  = 128'sh7FFF_FFFF;

   typedef struct packed {
      logic [P_W-1:0] numer;
      logic [Q_W-1:0] denom;
      logic           overflow;
   } convergent_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            csr_index;
      logic [IN_W-1:0] value;
      logic            known;
      convergent_type  result;
   } stim_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata   = '0;   // value_in[47:0]
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [63:0]       rsp_tdata;          // numer[31:0], denom[62:32], zero[63]
   logic              rsp_tuser;          // overflow
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_W-1:0]  csr_pwdata  = '0;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   logic [TOL_W-1:0]  tol_setting = TOL_RESET;
   logic [STEP_W-1:0] step_limit  = STEPS_RESET;

   convergent_type pending_convergents[$];
   stim_row_type   directed_rows[$];

   int failures     = 0;
   int results_seen = 0;
   int rsp_wait     = 0;
   int stall_count  = 0;
   bit quiet_gaps   = 1'b0;

   continued_fraction_approximator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic convergent_type best_convergent(input logic [IN_W-1:0] raw);
      logic signed [127:0] x, p, p_prev, p_next, q, q_prev, q_next;
      logic signed [127:0] frac, term, rem, err, lim;
      convergent_type res;
      res          = '0;
      x            = {{(128-IN_W){raw[IN_W-1]}}, raw};
      p            = x >>> FRAC_BITS;
      frac         = x & (UNIT - 1);
      p_prev       = 1;
      q            = 1;
      q_prev       = 0;
      for (int s = 1; s < step_limit; s++) begin
         err = x * q - (p <<< FRAC_BITS);
         if (err < 0) err = -err;
         lim = $signed({96'd0, tol_setting}) * q;
         if (err < lim || frac == 0) break;
         term = UNIT / frac;
         rem  = UNIT % frac;
         frac = (rem <<< FRAC_BITS) / frac;
         if (term > TERM_MAX) begin
            term         = TERM_MAX;
            res.overflow = 1'b1;
         end
         p_next = term * p + p_prev;
         q_next = term * q + q_prev;
         p_prev = p;
         q_prev = q;
         if (p_next > NUM_MAX) begin
            p_next       = NUM_MAX;
            res.overflow = 1'b1;
         end
         if (p_next < NUM_MIN) begin
            p_next       = NUM_MIN;
            res.overflow = 1'b1;
         end
         if (q_next > DEN_MAX) begin
            q_next       = DEN_MAX;
            res.overflow = 1'b1;
         end
         p = p_next;
         q = q_next;
         if (res.overflow) break;
      end
      res.numer = p[P_W-1:0];
      res.denom = q[Q_W-1:0];
      return res;
   endfunction

   function automatic int pick_gap();
      return quiet_gaps ? 0 : int'($urandom_range(0, GAP_MAX));
   endfunction

   function automatic logic [IN_W-1:0] random_value();
      logic signed [63:0] w;
      logic signed [63:0] num;
      logic [31:0]        lo;
      int                 k;
      int                 d;
      case ($urandom_range(0, 5))
         0: begin
            w = {$urandom, $urandom};
         end
         1: begin
            k = $urandom_range(0, 16);
            k = k - 8;
            w = {k, $urandom};
         end
         2: begin
            k   = $urandom_range(0, 400);
            num = 64'(k - 200);
            d   = $urandom_range(1, 60);
            k   = $urandom_range(0, 6);
            w   = (num <<< FRAC_BITS) / 64'(d) + 64'(k - 3);
         end
         3: begin
            k  = $urandom;
            lo = $urandom_range(1, 16);
            w  = {k, lo};
         end
         4: begin
            k = $urandom;
            w = {k, 32'd0};
         end
         default: begin
            k  = $urandom_range(0, 16);
            k  = k - 8;
            lo = 32'hFFFF_FFFF - $urandom_range(0, 999);
            w  = {k, lo};
         end
      endcase
      return w[IN_W-1:0];
   endfunction

   task automatic add_item(input logic [IN_W-1:0] v);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_ITEM;
      row.value = v;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_known(input logic [IN_W-1:0] v, input logic [P_W-1:0] numer,
                            input logic [Q_W-1:0] denom, input logic ovf);
      stim_row_type row;
      row                 = '0;
      row.kind            = ROW_ITEM;
      row.value           = v;
      row.known           = 1'b1;
      row.result.numer    = numer;
      row.result.denom    = denom;
      row.result.overflow = ovf;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_csr(input logic idx, input logic [CSR_W-1:0] data);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.csr_index = idx;
      row.value     = {16'd0, data};
      directed_rows = {directed_rows, row};
   endtask

   task automatic csr_cycle(input logic wr, input logic idx, input logic [CSR_W-1:0] data,
                            output logic [CSR_W-1:0] rd);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd          = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_register(input logic idx, input logic [CSR_W-1:0] data);
      logic [CSR_W-1:0] readback;
      logic [CSR_W-1:0] mask;
      csr_cycle(1'b1, idx, data, readback);
      csr_cycle(1'b0, idx, '0, readback);
      mask = (idx == REG_TOLERANCE) ? '1 : CSR_W'((1 << STEP_W) - 1);
      if ((readback & mask) !== (data & mask)) begin
         $error("register %0d readback: expected %h, got %h", idx, data & mask,
                readback & mask);
         failures++;
      end
      if (idx == REG_TOLERANCE) tol_setting = data;
      else step_limit = data[STEP_W-1:0];
   endtask

   task automatic send_value(input logic [IN_W-1:0] v, input convergent_type want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      pending_convergents = {pending_convergents, want};
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_convergents.size() != 0) @(posedge clock);
   endtask

   task automatic check_convergent();
      convergent_type want;
      if (pending_convergents.size() == 0) begin
         $error("transfer with no item outstanding: tdata %h tuser %b", rsp_tdata, rsp_tuser);
         failures++;
      end else begin
         want = pending_convergents.pop_front();
         if (rsp_tdata[31:0] !== want.numer) begin
            $error("numer: expected %0d, got %0d", $signed(want.numer),
                   $signed(rsp_tdata[31:0]));
            failures++;
         end
         if (rsp_tdata[62:32] !== want.denom) begin
            $error("denom: expected %0d, got %0d", want.denom, rsp_tdata[62:32]);
            failures++;
         end
         if (rsp_tuser !== want.overflow) begin
            $error("overflow: expected %b, got %b", want.overflow, rsp_tuser);
            failures++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tready && rsp_tvalid) begin
            check_convergent();
            results_seen++;
            rsp_wait = (results_seen == HOLD_AT) ? HOLD_CYCLES : pick_gap();
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_tready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel || reset) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      stim_row_type      row;
      logic [IN_W-1:0]   v;
      logic [TOL_W-1:0]  tol;
      logic [STEP_W-1:0] steps;

      add_known(48'h0, 32'd0, 31'd1, 1'b0);
      add_known(48'h5_0000_0000, 32'd5, 31'd1, 1'b0);
      add_known(-48'sh3_0000_0000, -32'sd3, 31'd1, 1'b0);
      add_item(48'h7FFF_FFFF_FFFF);
      add_known(48'h8000_0000_0000, -32'sd32768, 31'd1, 1'b0);
      add_item(48'hFFFF_FFFF_FFFF);
      add_item(PI_FIX);
      add_item(48'h0_8000_0000);
      add_csr(REG_TOLERANCE, 32'd0);
      add_known(48'h0, 32'd0, 31'd1, 1'b0);
      add_item(48'h2_8000_0000);
      add_known(48'h0_0000_0001, 32'd1, 31'h7FFF_FFFF, 1'b1);
      add_item(48'h7FFF_0000_0003);
      add_item(48'h8000_0000_0003);
      add_item(PI_FIX);
      add_csr(REG_MAX_STEPS, 32'd63);
      add_item(PI_FIX);
      add_item(SQRT2_FIX);
      add_item(48'h7FFF_FFFF_FFFF);
      add_csr(REG_TOLERANCE, 32'hFFFF_FFFF);
      add_item(PI_FIX);
      add_item(48'h0_FFFF_FFFF);
      add_csr(REG_MAX_STEPS, 32'd1);
      add_csr(REG_TOLERANCE, 32'd0);
      add_known(PI_FIX, 32'd3, 31'd1, 1'b0);
      add_known(48'hFFFF_FFFF_FFFF, -32'sd1, 31'd1, 1'b0);
      add_csr(REG_MAX_STEPS, 32'd0);
      add_known(PI_FIX, 32'd3, 31'd1, 1'b0);
      add_known(48'h8000_0000_0001, -32'sd32768, 31'd1, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_for_results();
            write_register(row.csr_index, row.value[CSR_W-1:0]);
         end else begin
            send_value(row.value, row.known ? row.result : best_convergent(row.value));
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         quiet_gaps = (phase == 2);
         case (phase)
            0: begin
               tol   = TOL_RESET;
               steps = STEPS_RESET;
            end
            1: begin
               tol   = '0;
               steps = '1;
            end
            2: begin
               tol   = $urandom;
               steps = STEP_W'($urandom_range(0, 63));
            end
            3: begin
               tol   = $urandom_range(0, 100000);
               steps = STEP_W'($urandom_range(2, 40));
            end
            4: begin
               tol   = '1;
               steps = STEP_W'($urandom_range(0, 63));
            end
            default: begin
               tol   = $urandom_range(0, 5000);
               steps = '1;
            end
         endcase
         write_register(REG_TOLERANCE, tol);
         write_register(REG_MAX_STEPS, {{(CSR_W-STEP_W){1'b0}}, steps});
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 3 && i == PHASE_ITEMS / 2) wait_for_results();
            v = random_value();
            send_value(v, best_convergent(v));
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/cfa_pkg.sv
rtl/core/cfa_mul.sv
rtl/core/cfa_div.sv
rtl/core/continued_fraction_approximator.sv
bench/testbench.sv
